FILE: hw/rtl/bpsc_pkg.sv
package bpsc_pkg;

    localparam int HIST_DEPTH = 65536;
    localparam int HIST_AW = 16;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int COUNT_WIDTH_DEF = 24;

    localparam logic [7:0] ESC_BYTE = 8'hFF;
    localparam logic [8:0] MAX_PAIRS_RST = 9'd256;
    localparam logic [23:0] MIN_COUNT_RST = 24'd10;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_TRAIN = 2'd1;
    localparam logic [1:0] CMD_COMP = 2'd2;
    localparam logic [1:0] CMD_DECOMP = 2'd3;

    localparam logic [1:0] REG_MAX_PAIRS = 2'd0;
    localparam logic [1:0] REG_MIN_COUNT = 2'd1;

    typedef struct packed {
        logic en;
        logic [HIST_AW-1:0] addr;
    } hist_req_t;

endpackage

FILE: hw/rtl/bpsc_hist_mem.sv
module bpsc_hist_mem
    import bpsc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic clk,
    input  hist_req_t wr_req,
    input  logic [COUNT_WIDTH-1:0] wr_data,
    input  hist_req_t rd_req,
    output logic [COUNT_WIDTH-1:0] rd_data
);

    logic [COUNT_WIDTH-1:0] mem [HIST_DEPTH];
    logic [COUNT_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            mem[wr_req.addr] <= wr_data;
        end
        if (rd_req.en)
        begin
            rd_data_reg <= mem[rd_req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/bpsc_tab_mem.sv
module bpsc_tab_mem
    import bpsc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int TAB_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic clk,
    input  logic wr_en,
    input  logic [TAB_AW-1:0] wr_addr,
    input  logic [15:0] wr_data,
    input  logic rd_en,
    input  logic [TAB_AW-1:0] rd_addr,
    output logic [15:0] rd_data
);

    logic [15:0] mem [TABLE_DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/byte_pair_substitution_codec_top.sv
// Byte-pair substitution codec with an escape token.
// Input channel (in_valid/in_ready) takes one word: command, data_byte, in_last.
// Output channel (out_valid/out_ready) gives out_byte, out_last and table_size.
// Configuration channel (cfg_valid/cfg_ready) is always ready: index 0 writes
// max_pairs, index 1 writes min_count, other indexes are ignored.
// One sequencer drives a histogram memory read/modify/write port and the pair
// table memory read and write ports; the block takes one word at a time and
// is ready again only after its output words are taken.
// Train reads a pair's histogram count and writes it back incremented; on a last
// byte the end-of-block scan visits every histogram entry once, one per cycle,
// clearing it as it goes. Compress searches the table one entry per cycle.
// Each output word then occupies the output register until out_ready is high;
// a stalled receiver holds the block not ready.
// After reset a clearing pass zeroes every histogram entry while in_ready
// stays low; configuration writes are taken during it.
module byte_pair_substitution_codec_top
    import bpsc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [1:0] command,
    input  logic [7:0] data_byte,
    input  logic in_last,
    output logic out_valid,
    input  logic out_ready,
    output logic [7:0] out_byte,
    output logic out_last,
    output logic [8:0] table_size,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int TAB_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR = 3'd1;
    localparam logic [2:0] S_TRWR = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_CSRCH = 3'd4;
    localparam logic [2:0] S_DREAD = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [16:0] scan_reg, scan_next;
    logic pend_reg, pend_next;
    logic [15:0] pend_addr_reg, pend_addr_next;
    logic [8:0] srch_reg, srch_next;
    logic [8:0] pend_idx_reg, pend_idx_next;
    logic [8:0] tcount_reg, tcount_next;
    logic [7:0] held_reg, held_next;
    logic held_valid_reg, held_valid_next;
    logic esc_reg, esc_next;
    logic [7:0] b_reg, b_next;
    logic last_reg, last_next;
    logic [8:0] max_pairs_reg;
    logic [23:0] min_count_reg;
    logic [7:0] ob_byte_reg [2];
    logic [1:0] ob_last_reg;
    logic [1:0] ocnt_reg;

    logic [1:0] e_n;
    logic [7:0] e_b0, e_b1;
    logic e_l0, e_l1;

    hist_req_t hwr, hrd;
    logic [COUNT_WIDTH-1:0] hwr_data, hrd_data;
    logic twr_en, trd_en;
    logic [TAB_AW-1:0] twr_addr, trd_addr;
    logic [15:0] trd_data;
    logic [8:0] limit;
    logic accept;

    bpsc_hist_mem #(.COUNT_WIDTH(COUNT_WIDTH)) u_hist (
        .clk(clk), .wr_req(hwr), .wr_data(hwr_data), .rd_req(hrd), .rd_data(hrd_data)
    );

    bpsc_tab_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_tab (
        .clk(clk), .wr_en(twr_en), .wr_addr(twr_addr), .wr_data(pend_addr_reg),
        .rd_en(trd_en), .rd_addr(trd_addr), .rd_data(trd_data)
    );

    assign in_ready = (state_reg == S_IDLE) && (ocnt_reg == 2'd0);
    assign accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = (ocnt_reg != 2'd0);
    assign out_byte = ob_byte_reg[0];
    assign out_last = ob_last_reg[0];
    assign table_size = tcount_reg;
    assign limit = (max_pairs_reg > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH) : max_pairs_reg;
    assign twr_addr = tcount_reg[TAB_AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        scan_next = scan_reg;
        pend_next = pend_reg;
        pend_addr_next = pend_addr_reg;
        srch_next = srch_reg;
        pend_idx_next = pend_idx_reg;
        tcount_next = tcount_reg;
        held_next = held_reg;
        held_valid_next = held_valid_reg;
        esc_next = esc_reg;
        b_next = b_reg;
        last_next = last_reg;
        e_n = 2'd0;
        e_b0 = held_reg;
        e_l0 = 1'b0;
        e_b1 = b_reg;
        e_l1 = last_reg;
        hwr = '0;
        hwr_data = '0;
        hrd = '0;
        twr_en = 1'b0;
        trd_en = 1'b0;
        trd_addr = srch_reg[TAB_AW-1:0];

        case (state_reg)
            S_CLR:
            begin
                hwr.en = 1'b1;
                hwr.addr = scan_reg[HIST_AW-1:0];
                if (scan_reg[HIST_AW-1:0] == HIST_AW'(HIST_DEPTH - 1))
                begin
                    scan_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 17'd1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    b_next = data_byte;
                    last_next = in_last;
                    case (command)
                        CMD_CLEAR:
                        begin
                            tcount_next = '0;
                            held_valid_next = 1'b0;
                            esc_next = 1'b0;
                        end
                        CMD_TRAIN:
                        begin
                            if (held_valid_reg)
                            begin
                                hrd.en = 1'b1;
                                hrd.addr = {held_reg, data_byte};
                                state_next = S_TRWR;
                            end
                            else
                            begin
                                held_next = data_byte;
                                held_valid_next = !in_last;
                                if (in_last)
                                begin
                                    scan_next = '0;
                                    pend_next = 1'b0;
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        CMD_COMP:
                        begin
                            if (held_valid_reg)
                            begin
                                srch_next = '0;
                                pend_next = 1'b0;
                                state_next = S_CSRCH;
                            end
                            else if (in_last)
                            begin
                                e_n = 2'd1;
                                e_b0 = data_byte;
                                e_l0 = 1'b1;
                            end
                            else
                            begin
                                held_next = data_byte;
                                held_valid_next = 1'b1;
                            end
                        end
                        CMD_DECOMP:
                        begin
                            if (esc_reg)
                            begin
                                esc_next = 1'b0;
                                if (9'(data_byte) < tcount_reg)
                                begin
                                    trd_en = 1'b1;
                                    trd_addr = data_byte[TAB_AW-1:0];
                                    state_next = S_DREAD;
                                end
                                else
                                begin
                                    e_n = 2'd2;
                                    e_b0 = ESC_BYTE;
                                    e_b1 = data_byte;
                                    e_l1 = in_last;
                                end
                            end
                            else if (data_byte == ESC_BYTE && !in_last)
                            begin
                                esc_next = 1'b1;
                            end
                            else
                            begin
                                e_n = 2'd1;
                                e_b0 = data_byte;
                                e_l0 = in_last;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TRWR:
            begin
                hwr.en = 1'b1;
                hwr.addr = {held_reg, b_reg};
                hwr_data = (&hrd_data) ? hrd_data : hrd_data + COUNT_WIDTH'(1);
                held_next = b_reg;
                held_valid_next = !last_reg;
                if (last_reg)
                begin
                    scan_next = '0;
                    pend_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // Read one entry per cycle; the entry read last cycle is judged
                // and zeroed now.
                if (!scan_reg[16])
                begin
                    hrd.en = 1'b1;
                    hrd.addr = scan_reg[HIST_AW-1:0];
                    pend_addr_next = scan_reg[HIST_AW-1:0];
                    scan_next = scan_reg + 17'd1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    hwr.en = 1'b1;
                    hwr.addr = pend_addr_reg;
                    if (33'(hrd_data) > 33'(min_count_reg) && tcount_reg < limit)
                    begin
                        twr_en = 1'b1;
                        tcount_next = tcount_reg + 9'd1;
                    end
                end
                if (scan_reg[16] && !pend_reg)
                begin
                    held_valid_next = 1'b0;
                    scan_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_CSRCH:
            begin
                if (pend_reg && trd_data == {held_reg, b_reg})
                begin
                    e_n = 2'd2;
                    e_b0 = ESC_BYTE;
                    e_b1 = pend_idx_reg[7:0];
                    e_l1 = last_reg;
                    held_valid_next = 1'b0;
                    pend_next = 1'b0;
                    state_next = S_IDLE;
                end
                else if (srch_reg < tcount_reg)
                begin
                    trd_en = 1'b1;
                    pend_idx_next = srch_reg;
                    srch_next = srch_reg + 9'd1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    e_b0 = held_reg;
                    e_l0 = 1'b0;
                    e_n = last_reg ? 2'd2 : 2'd1;
                    e_l1 = 1'b1;
                    held_next = b_reg;
                    held_valid_next = !last_reg;
                    state_next = S_IDLE;
                end
            end
            S_DREAD:
            begin
                e_n = 2'd2;
                e_b0 = trd_data[15:8];
                e_b1 = trd_data[7:0];
                e_l1 = last_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            scan_reg <= '0;
            pend_reg <= 1'b0;
            tcount_reg <= '0;
            held_reg <= '0;
            held_valid_reg <= 1'b0;
            esc_reg <= 1'b0;
            max_pairs_reg <= MAX_PAIRS_RST;
            min_count_reg <= MIN_COUNT_RST;
            ocnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg <= scan_next;
            pend_reg <= pend_next;
            tcount_reg <= tcount_next;
            held_reg <= held_next;
            held_valid_reg <= held_valid_next;
            esc_reg <= esc_next;
            if (cfg_valid)
            begin
                if (cfg_index == REG_MAX_PAIRS)
                begin
                    max_pairs_reg <= cfg_data[8:0];
                end
                else if (cfg_index == REG_MIN_COUNT)
                begin
                    min_count_reg <= cfg_data;
                end
            end
            if (e_n != 2'd0)
            begin
                ocnt_reg <= e_n;
            end
            else if (out_valid && out_ready)
            begin
                ocnt_reg <= ocnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        srch_reg <= srch_next;
        pend_idx_reg <= pend_idx_next;
        b_reg <= b_next;
        last_reg <= last_next;
        if (e_n != 2'd0)
        begin
            ob_byte_reg[0] <= e_b0;
            ob_last_reg[0] <= e_l0;
            ob_byte_reg[1] <= e_b1;
            ob_last_reg[1] <= e_l1;
        end
        else if (out_valid && out_ready)
        begin
            ob_byte_reg[0] <= ob_byte_reg[1];
            ob_last_reg[0] <= ob_last_reg[1];
        end
    end

    a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !out_valid)
        else $error("output word during histogram clear");

    a_tcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tcount_reg <= 9'(TABLE_DEPTH))
        else $error("table count beyond depth");

    a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg != 2'd3)
        else $error("output buffer overfilled");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE && !out_valid)
        else $error("ready while busy");

endmodule

FILE: sim/tb_byte_pair_substitution_codec_top.sv
module tb_byte_pair_substitution_codec_top;
    import bpsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] byte_val;
        logic       last;
        logic [8:0] size;
    } codec_word_t;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       last;
        bit         typed;
        int         n;
        logic [7:0] b0;
        logic       l0;
        logic [7:0] b1;
        logic       l1;
        logic [8:0] size;
    } vector_t;

    localparam int SCAN_SETTLE = 70000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] command = CMD_CLEAR;
    logic [7:0] data_byte = 8'd0;
    logic in_last = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] out_byte;
    logic out_last;
    logic [8:0] table_size;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = REG_MAX_PAIRS;
    logic [23:0] cfg_data = 24'd0;

    byte_pair_substitution_codec_top dut (.*);

    always #6 clk = ~clk;

    // Predictor state.
    int unsigned pair_counts[HIST_DEPTH];
    logic [15:0] pairs[TABLE_DEPTH_DEF];
    logic [8:0] pair_total;
    logic [7:0] held;
    bit held_ok;
    bit esc_wait;
    logic [8:0] pair_limit;
    logic [23:0] count_floor;

    codec_word_t expected_words[$];
    codec_word_t step_words[$];

    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int scans = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    bit scan_busy = 1'b0;
    logic [8:0] peak_size = 9'd0;
    logic [7:0] alphabet[4];

    function automatic void put_word(logic [7:0] b, logic l);
        codec_word_t w;
        w.byte_val = b;
        w.last = l;
        w.size = pair_total;
        step_words.push_back(w);
    endfunction

    function automatic int find_entry(logic [7:0] a, logic [7:0] b);
        for (int j = 0; j < pair_total; j++)
            if (pairs[j] == {a, b})
                return j;
        return -1;
    endfunction

    function automatic void build_pairs();
        int lim;
        lim = (pair_limit > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : pair_limit;
        for (int code = 0; code < HIST_DEPTH && pair_total < lim; code++)
            if (pair_counts[code] > count_floor)
            begin
                pairs[pair_total] = code[15:0];
                pair_total++;
            end
        foreach (pair_counts[i])
            pair_counts[i] = 0;
    endfunction

    // Works out the words one input word causes, into step_words.
    function automatic void codec_step(logic [1:0] cmd, logic [7:0] b, logic l);
        int j;
        step_words.delete();
        case (cmd)
            CMD_CLEAR:
            begin
                pair_total = '0;
                held_ok = 0;
                esc_wait = 0;
            end
            CMD_TRAIN:
            begin
                if (held_ok && pair_counts[{held, b}] < 32'hFF_FFFF)
                    pair_counts[{held, b}]++;
                held = b;
                held_ok = 1;
                if (l)
                begin
                    build_pairs();
                    held_ok = 0;
                end
            end
            CMD_COMP:
            begin
                j = held_ok ? find_entry(held, b) : -1;
                if (j >= 0)
                begin
                    put_word(ESC_BYTE, 1'b0);
                    put_word(j[7:0], l);
                    held_ok = 0;
                end
                else
                begin
                    if (held_ok)
                        put_word(held, 1'b0);
                    if (l)
                    begin
                        put_word(b, 1'b1);
                        held_ok = 0;
                    end
                    else
                    begin
                        held = b;
                        held_ok = 1;
                    end
                end
            end
            default:
            begin
                if (esc_wait)
                begin
                    esc_wait = 0;
                    if (b < pair_total)
                    begin
                        put_word(pairs[b][15:8], 1'b0);
                        put_word(pairs[b][7:0], l);
                    end
                    else
                    begin
                        put_word(ESC_BYTE, 1'b0);
                        put_word(b, l);
                    end
                end
                else if (b == ESC_BYTE && !l)
                    esc_wait = 1;
                else
                    put_word(b, l);
            end
        endcase
    endfunction

    task automatic send_word(logic [1:0] cmd, logic [7:0] b, logic l, vector_t v);
        codec_word_t w;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        data_byte <= b;
        in_last <= l;
        do @(posedge clk); while (!in_ready);
        words_in++;
        codec_step(cmd, b, l);
        if (cmd == CMD_TRAIN && l)
        begin
            scan_busy = 1;
            scans++;
        end
        if (v.typed)
        begin
            step_words.delete();
            if (v.n > 0)
            begin
                w.byte_val = v.b0; w.last = v.l0; w.size = v.size;
                step_words.push_back(w);
            end
            if (v.n > 1)
            begin
                w.byte_val = v.b1; w.last = v.l1; w.size = v.size;
                step_words.push_back(w);
            end
        end
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
        if (pair_total > peak_size)
            peak_size = pair_total;
    endtask

    task automatic send(logic [1:0] cmd, logic [7:0] b, logic l);
        vector_t none;
        none.typed = 0;
        send_word(cmd, b, l, none);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_MAX_PAIRS)
            pair_limit = val[8:0];
        else if (idx == REG_MIN_COUNT)
            count_floor = val;
    endtask

    // Waits for the block to go idle; a training scan gives no word back.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        if (scan_busy)
            repeat (SCAN_SETTLE) @(posedge clk);
        scan_busy = 0;
    endtask

    function automatic logic [7:0] pick();
        return ($urandom_range(99) < 6) ? ESC_BYTE : alphabet[$urandom_range(3)];
    endfunction

    task automatic train_block();
        int len;
        len = $urandom_range(50, 20);
        for (int i = 0; i < len; i++)
            send(CMD_TRAIN, alphabet[$urandom_range(3)], i == len - 1);
    endtask

    task automatic random_phase(int count);
        int len, start, r;
        for (int a = 0; a < 4; a++)
            alphabet[a] = 8'($urandom_range(254));
        train_block();
        start = words_in;
        while (words_in - start < count)
        begin
            r = $urandom_range(99);
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 2);
            if (r < 45)
            begin
                for (int i = 0; i < len; i++)
                    send(CMD_COMP, pick(), i == len - 1);
            end
            else if (r < 85)
            begin
                for (int i = 0; i < len; i++)
                    if (!esc_wait && $urandom_range(2) == 0 && i != len - 1)
                        send(CMD_DECOMP, ESC_BYTE, 1'b0);
                    else if (esc_wait)
                        send(CMD_DECOMP, ($urandom_range(5) == 0 || pair_total == 0) ?
                             8'($urandom_range(255)) : 8'($urandom_range(pair_total - 1)),
                             i == len - 1);
                    else
                        send(CMD_DECOMP, 8'($urandom_range(255)), i == len - 1);
            end
            else if (r < 99)
            begin
                // Noise: any command on any byte, but never a training end.
                logic [1:0] c;
                c = 2'($urandom_range(3));
                if (c == CMD_CLEAR && $urandom_range(3) != 0)
                    c = CMD_COMP;
                send(c, 8'($urandom_range(255)),
                     (c == CMD_TRAIN) ? 1'b0 : 1'($urandom_range(1)));
            end
            else if (scans < 7)
                train_block();
        end
    endtask

    vector_t vectors[] = '{
        '{CMD_DECOMP, 8'h00, 1, 1, 1, 8'h00, 1, 8'h00, 0, 9'd0},
        '{CMD_DECOMP, 8'hFF, 1, 1, 1, 8'hFF, 1, 8'h00, 0, 9'd0},
        '{CMD_DECOMP, 8'hFF, 0, 1, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_DECOMP, 8'h05, 1, 1, 2, 8'hFF, 0, 8'h05, 1, 9'd0},
        '{CMD_COMP,   8'hAB, 1, 1, 1, 8'hAB, 1, 8'h00, 0, 9'd0},
        '{CMD_COMP,   8'hFF, 0, 1, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_COMP,   8'hFF, 1, 1, 2, 8'hFF, 0, 8'hFF, 1, 9'd0},
        '{CMD_TRAIN,  8'h12, 0, 1, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_TRAIN,  8'h34, 1, 1, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_TRAIN,  8'h56, 0, 1, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_TRAIN,  8'h78, 1, 1, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_COMP,   8'h12, 0, 0, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_COMP,   8'h34, 1, 0, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_COMP,   8'h56, 0, 0, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_COMP,   8'h78, 0, 0, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_COMP,   8'h00, 1, 0, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_DECOMP, 8'hFF, 0, 0, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_DECOMP, 8'h01, 1, 0, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_DECOMP, 8'hFF, 0, 0, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_DECOMP, 8'h02, 0, 1, 2, 8'hFF, 0, 8'h02, 0, 9'd2},
        '{CMD_DECOMP, 8'h00, 1, 1, 1, 8'h00, 1, 8'h00, 0, 9'd2},
        '{CMD_TRAIN,  8'h9A, 0, 0, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_COMP,   8'hBC, 1, 0, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_CLEAR,  8'h00, 0, 1, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_COMP,   8'h12, 0, 1, 0, 8'h00, 0, 8'h00, 0, 9'd0},
        '{CMD_COMP,   8'h34, 1, 1, 2, 8'h12, 0, 8'h34, 1, 9'd0}
    };

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        static int hold_left = 0;
        static int holds_done = 0;
        if (hold_request > holds_done)
        begin
            holds_done++;
            hold_left = 600;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        codec_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            words_out++;
            scan_busy = 0;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: out_byte %h out_last %b", out_byte, out_last);
                errors++;
            end
            else
            begin
                w = expected_words.pop_front();
                if (out_byte !== w.byte_val)
                begin
                    $error("out_byte expected %h actual %h", w.byte_val, out_byte);
                    errors++;
                end
                if (out_last !== w.last)
                begin
                    $error("out_last expected %b actual %b", w.last, out_last);
                    errors++;
                end
                if (table_size !== w.size)
                begin
                    $error("table_size expected %0d actual %0d", w.size, table_size);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("byte_pair_substitution_codec_top verification failed");
        $finish;
    end

    initial
    begin
        foreach (pair_counts[i])
            pair_counts[i] = 0;
        foreach (pairs[i])
            pairs[i] = 16'd0;
        pair_total = '0;
        held = 8'd0;
        held_ok = 0;
        esc_wait = 0;
        pair_limit = MAX_PAIRS_RST;
        count_floor = MIN_COUNT_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_MAX_PAIRS, 24'd256);
        write_reg(REG_MIN_COUNT, 24'd0);
        write_reg(2'd2, 24'hFF_FFFF);
        write_reg(2'd3, 24'h00_0001);
        foreach (vectors[i])
            send_word(vectors[i].cmd, vectors[i].data, vectors[i].last, vectors[i]);
        drain();

        send_idle_pct = 8;
        recv_idle_pct = 79;
        write_reg(REG_MAX_PAIRS, 24'd3);
        write_reg(REG_MIN_COUNT, 24'd1);
        random_phase(450);
        drain();

        send_idle_pct = 79;
        recv_idle_pct = 8;
        write_reg(REG_MAX_PAIRS, 24'd511);
        write_reg(REG_MIN_COUNT, 24'd2);
        random_phase(450);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_MAX_PAIRS, 24'd0);
        write_reg(REG_MIN_COUNT, 24'hFF_FFFF);
        hold_request = 1;
        random_phase(450);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Sent %0d input words and checked %0d output words.", words_in, words_out);
        $display("Ran %0d training scans; the pair table reached %0d entries.",
                 scans, peak_size);
        if (errors == 0)
            $display("byte_pair_substitution_codec_top verification clean");
        else
            $display("byte_pair_substitution_codec_top verification failed");
        $finish;
    end

endmodule

FILE: byte_pair_substitution_codec_top.f
hw/rtl/bpsc_pkg.sv
hw/rtl/bpsc_hist_mem.sv
hw/rtl/bpsc_tab_mem.sv
hw/rtl/byte_pair_substitution_codec_top.sv
sim/tb_byte_pair_substitution_codec_top.sv
